// ----- rtl/rxmf_pkg.sv -----
package rxmf_pkg;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam int MIN_SIZE         = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic emit;
		logic line_last;
		logic frame_last;
	} pos_flags_t;

	// Median of five: rank each sample against the others, ties broken by position,
	// and pick the one with two samples below it.
	function automatic logic [CH_W-1:0] median5(input logic [4:0][CH_W-1:0] v);
		logic [2:0]      rank [5];
		logic [CH_W-1:0] res;
		res = '0;
		for (int i = 0; i < 5; i++) begin
			rank[i] = 3'd0;
			for (int j = 0; j < 5; j++) begin
				if (j != i) begin
					if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
						rank[i] = rank[i] + 3'd1;
					end
				end
			end
		end
		for (int i = 0; i < 5; i++) begin
			if (rank[i] == 3'd2) begin
				res = v[i];
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/rxmf_ram.sv -----
module rxmf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/rxmf_pos.sv -----
module rxmf_pos
	import rxmf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          accept,
	input  logic                          frame_start,
	output logic [$clog2(MAX_WIDTH)-1:0]  idx,
	output pos_flags_t                    flags
);

	localparam int IDX_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CWW   = (WW > FW_W) ? WW : FW_W;
	localparam int CHW   = (HW > FH_W) ? HW : FH_W;
	localparam int W_RST = (FRAME_WIDTH_RST < MIN_SIZE) ? MIN_SIZE :
		((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST);
	localparam int H_RST = (FRAME_HEIGHT_RST < MIN_SIZE) ? MIN_SIZE :
		((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST);

	logic [WW-1:0]    w_eff_q;
	logic [HW-1:0]    h_eff_q;
	logic [IDX_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [CWW-1:0]   fw_ext;
	logic [CHW-1:0]   fh_ext;
	logic [WW-1:0]    w_clamp;
	logic [HW-1:0]    h_clamp;
	logic [IDX_W-1:0] col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [WW-1:0]    col_inc;
	logic [HW-1:0]    row_inc;
	logic             col_wrap;
	logic             row_wrap;

	// Clamp written sizes into the supported range
	always_comb begin
		fw_ext = CWW'(cfg_data[FW_W-1:0]);
		fh_ext = CHW'(cfg_data[FH_W-1:0]);
		if (fw_ext < CWW'(MIN_SIZE)) begin
			w_clamp = WW'(MIN_SIZE);
		end else if (fw_ext > CWW'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = fw_ext[WW-1:0];
		end
		if (fh_ext < CHW'(MIN_SIZE)) begin
			h_clamp = HW'(MIN_SIZE);
		end else if (fh_ext > CHW'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = fh_ext[HW-1:0];
		end
	end

	// Hold the effective frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= WW'(W_RST);
			h_eff_q <= HW'(H_RST);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  w_eff_q <= w_clamp;
				REG_FRAME_HEIGHT: h_eff_q <= h_clamp;
				default:          ;
			endcase
		end
	end

	// Position of the incoming pixel
	always_comb begin
		col_cur  = frame_start ? '0 : col_q;
		row_cur  = frame_start ? '0 : row_q;
		col_inc  = WW'(col_cur) + WW'(1);
		row_inc  = HW'(row_cur) + HW'(1);
		col_wrap = (col_inc >= w_eff_q);
		row_wrap = (row_inc >= h_eff_q);
		idx      = col_cur;
		flags.emit = (row_cur >= ROW_W'(2)) && (col_cur >= IDX_W'(2))
			&& (WW'(col_cur) < w_eff_q) && (HW'(row_cur) < h_eff_q);
		flags.line_last  = (col_inc == w_eff_q);
		flags.frame_last = (col_inc == w_eff_q) && (row_inc == h_eff_q);
	end

	// Advance column and line on each pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[IDX_W-1:0];
				row_q <= row_cur;
			end
		end
	end

endmodule

// ----- rtl/rxmf_core.sv -----
module rxmf_core
	import rxmf_pkg::*;
#(
	parameter int IDX_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [PIX_W-1:0] px_in,
	input  pos_flags_t       flags_in,
	input  logic [IDX_W-1:0] idx_in,
	input  logic [PIX_W-1:0] upper_rd,
	input  logic [PIX_W-1:0] middle_rd,
	input  logic             out_ready,
	output logic             in_ready,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_idx,
	output logic [PIX_W-1:0] upper_wd,
	output logic [PIX_W-1:0] middle_wd,
	output logic             out_valid,
	output logic [PIX_W-1:0] out_px,
	output pos_flags_t       out_flags
);

	logic             s1_valid;
	logic [PIX_W-1:0] px_s1;
	pos_flags_t       flags_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             byp_s1;
	logic [PIX_W-1:0] byp_top_s1;
	logic [PIX_W-1:0] byp_mid_s1;

	logic             s2_valid;
	logic [PIX_W-1:0] px_s2;
	pos_flags_t       flags_s2;

	// Window: columns col-1 (top, mid, bottom) and col-2 (top, bottom)
	logic [PIX_W-1:0] win_top1_q, win_mid1_q, win_bot1_q;
	logic [PIX_W-1:0] win_top2_q, win_bot2_q;

	logic             adv;
	logic [PIX_W-1:0] top_eff;
	logic [PIX_W-1:0] mid_eff;
	logic [PIX_W-1:0] med;

	// Stage 1 moves on unless it holds a result that the full output register blocks
	assign adv      = s1_valid && (!s2_valid || out_ready || !flags_s1.emit);
	assign in_ready = !s1_valid || adv;

	// Forward the previous pixel's store update when it hits the same column
	assign top_eff = byp_s1 ? byp_top_s1 : upper_rd;
	assign mid_eff = byp_s1 ? byp_mid_s1 : middle_rd;

	assign wr_en     = adv;
	assign wr_idx    = idx_s1;
	assign upper_wd  = mid_eff;
	assign middle_wd = px_s1;

	// Five-point median per channel
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			med[k*CH_W +: CH_W] = median5({win_top2_q[k*CH_W +: CH_W],
				top_eff[k*CH_W +: CH_W], win_mid1_q[k*CH_W +: CH_W],
				win_bot2_q[k*CH_W +: CH_W], px_s1[k*CH_W +: CH_W]});
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
			byp_s1   <= s1_valid && (idx_s1 == idx_in);
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= px_in;
			flags_s1   <= flags_in;
			idx_s1     <= idx_in;
			byp_top_s1 <= mid_eff;
			byp_mid_s1 <= px_s1;
		end
	end

	// Shift the window as each pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_top1_q <= '0;
			win_mid1_q <= '0;
			win_bot1_q <= '0;
			win_top2_q <= '0;
			win_bot2_q <= '0;
		end else if (adv) begin
			win_top2_q <= win_top1_q;
			win_bot2_q <= win_bot1_q;
			win_top1_q <= top_eff;
			win_mid1_q <= mid_eff;
			win_bot1_q <= px_s1;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv && flags_s1.emit) begin
			s2_valid <= 1'b1;
		end else if (out_ready) begin
			s2_valid <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv && flags_s1.emit) begin
			px_s2    <= med;
			flags_s2 <= flags_s1;
		end
	end

	assign out_valid = s2_valid;
	assign out_px    = px_s2;
	assign out_flags = flags_s2;

endmodule

// ----- rtl/rgb_x_median_filter.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_red, in_green, in_blue, frame_start
// out     | output    | out_valid / out_ready | out_red, out_green, out_blue,
//         |           |                       | line_end, frame_end
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle sustained while the output is not stalled; a result is registered
// in the output register from stage 1, which holds the pixel and its line-store reads.
// Reset clears the counters, window and valid flags; line stores are not cleared.
// A stalled output register holds its result; the input stalls only when stage 1 also
// holds a result. cfg_ready is always high.
module rgb_x_median_filter
	import rxmf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CH_W-1:0]       in_red,
	input  logic [CH_W-1:0]       in_green,
	input  logic [CH_W-1:0]       in_blue,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       out_red,
	output logic [CH_W-1:0]       out_green,
	output logic [CH_W-1:0]       out_blue,
	output logic                  line_end,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_WIDTH);

	logic             accept;
	logic [IDX_W-1:0] idx;
	pos_flags_t       flags;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [PIX_W-1:0] upper_wd, middle_wd;
	logic [PIX_W-1:0] upper_rd, middle_rd;
	logic [PIX_W-1:0] out_px;
	pos_flags_t       out_flags;

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Frame position and configuration
	rxmf_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.frame_start (frame_start),
		.idx         (idx),
		.flags       (flags)
	);

	// Line two above
	rxmf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx),
		.wr_data (upper_wd),
		.rd_en   (accept),
		.rd_addr (idx),
		.rd_data (upper_rd)
	);

	// Line one above
	rxmf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx),
		.wr_data (middle_wd),
		.rd_en   (accept),
		.rd_addr (idx),
		.rd_data (middle_rd)
	);

	// Window, median and output register
	rxmf_core #(
		.IDX_W (IDX_W)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.px_in     ({in_red, in_green, in_blue}),
		.flags_in  (flags),
		.idx_in    (idx),
		.upper_rd  (upper_rd),
		.middle_rd (middle_rd),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.upper_wd  (upper_wd),
		.middle_wd (middle_wd),
		.out_valid (out_valid),
		.out_px    (out_px),
		.out_flags (out_flags)
	);

	assign out_red   = out_px[2*CH_W +: CH_W];
	assign out_green = out_px[CH_W +: CH_W];
	assign out_blue  = out_px[0 +: CH_W];
	assign line_end  = out_flags.line_last;
	assign frame_end = out_flags.frame_last;

endmodule

// ----- rtl/rxmf_checker.sv -----
module rxmf_checker
	import rxmf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [CH_W-1:0]       out_red,
	input logic [CH_W-1:0]       out_green,
	input logic [CH_W-1:0]       out_blue,
	input logic                  line_end,
	input logic                  frame_end
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(line_end) && $stable(frame_end))
		else $error("stalled result changed");

	// Frame end only on a line end
	a_frame_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> line_end)
		else $error("frame_end without line_end");

	// A fresh result follows its pixel transfer through stage 1 and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching pixel transfer");

	// Empty output register never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

bind rgb_x_median_filter rxmf_checker u_rxmf_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import rxmf_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int MAX_H          = 4096;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MIX_ITEMS      = 340;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_start;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            line_end;
		logic            frame_end;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CH_W-1:0]       in_red = '0;
	logic [CH_W-1:0]       in_green = '0;
	logic [CH_W-1:0]       in_blue = '0;
	logic                  frame_start = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CH_W-1:0]       out_red;
	logic [CH_W-1:0]       out_green;
	logic [CH_W-1:0]       out_blue;
	logic                  line_end;
	logic                  frame_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Pixels waiting to be sent and filtered pixels waiting to come back
	pixel_t    pixel_queue[$];
	filtered_t expected_pixels[$];
	pixel_t    next_pixel;
	filtered_t want;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned pixels_sent = 0;
	int unsigned results_checked = 0;
	int unsigned cfg_write_count = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned frame_w = FRAME_WIDTH_RST;
	int unsigned frame_h = FRAME_HEIGHT_RST;

	// Filter state as the block should hold it
	logic [FW_W-1:0] width_reg = FW_W'(FRAME_WIDTH_RST);
	logic [FH_W-1:0] height_reg = FH_W'(FRAME_HEIGHT_RST);
	bit [PIX_W-1:0]  upper_store [MAX_W];
	bit [PIX_W-1:0]  middle_store [MAX_W];
	bit [PIX_W-1:0]  win [6];
	int unsigned     col_cnt = 0;
	int unsigned     row_cnt = 0;

	rgb_x_median_filter #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.line_end   (line_end),
		.frame_end  (frame_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [CH_W-1:0] median_of_five(input logic [CH_W-1:0] a, b, c, d, e);
		logic [CH_W-1:0] s [5];
		logic [CH_W-1:0] t;
		s[0] = a;
		s[1] = b;
		s[2] = c;
		s[3] = d;
		s[4] = e;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4 - i; j++) begin
				if (s[j] > s[j + 1]) begin
					t        = s[j];
					s[j]     = s[j + 1];
					s[j + 1] = t;
				end
			end
		end
		return s[2];
	endfunction

	// Advance the filter state by one pixel and queue the filtered pixel it yields
	task automatic filter_pixel(input pixel_t p);
		int unsigned     w, h, col, row, idx, sh;
		bit [PIX_W-1:0]  px, top, mid;
		logic [CH_W-1:0] lvl [3];
		filtered_t       r;
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, MAX_H);
		if (p.frame_start) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		col = col_cnt;
		row = row_cnt;
		px  = {p.red, p.green, p.blue};
		idx = (col < MAX_W) ? col : 0;
		top = upper_store[idx];
		mid = middle_store[idx];
		upper_store[idx]  = mid;
		middle_store[idx] = px;

		// Corners of the window plus its center, per color
		if (row >= 2 && col >= 2 && col < w && row < h) begin
			for (int k = 0; k < 3; k++) begin
				sh = PIX_W - CH_W * (k + 1);
				lvl[k] = median_of_five(win[3][sh +: CH_W], top[sh +: CH_W],
					win[1][sh +: CH_W], win[5][sh +: CH_W], px[sh +: CH_W]);
			end
			r.red       = lvl[0];
			r.green     = lvl[1];
			r.blue      = lvl[2];
			r.line_end  = (col == w - 1);
			r.frame_end = (col == w - 1) && (row == h - 1);
			expected_pixels.push_back(r);
		end

		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = top;
		win[1] = mid;
		win[2] = px;

		if (col + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col_cnt = col + 1;
		end
	endtask

	// Driver: predict on each pixel transfer, then present the next pending pixel
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				filter_pixel(pixel_t'({in_red, in_green, in_blue, frame_start}));
				pixels_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pixel = pixel_queue.pop_front();
					in_valid    <= 1'b1;
					in_red      <= next_pixel.red;
					in_green    <= next_pixel.green;
					in_blue     <= next_pixel.blue;
					frame_start <= next_pixel.frame_start;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result: r=%0d g=%0d b=%0d line_end=%0b frame_end=%0b",
						out_red, out_green, out_blue, line_end, frame_end);
				end
			end else begin
				want = expected_pixels.pop_front();
				if (out_red !== want.red || out_green !== want.green ||
						out_blue !== want.blue || line_end !== want.line_end ||
						frame_end !== want.frame_end) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch at result %0d: expected r=%0d g=%0d b=%0d le=%0b fe=%0b",
							results_checked, want.red, want.green, want.blue,
							want.line_end, want.frame_end);
						$display("                      actual   r=%0d g=%0d b=%0d le=%0b fe=%0b",
							out_red, out_green, out_blue, line_end, frame_end);
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Track register writes in the prediction
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					width_reg = cfg_data[FW_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_reg = cfg_data[FH_W-1:0];
				end
				default: begin
				end
			endcase
			cfg_write_count++;
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_pixel(input logic [CH_W-1:0] r, g, b, input logic fs);
		pixel_t p;
		p.red         = r;
		p.green       = g;
		p.blue        = b;
		p.frame_start = fs;
		pixel_queue.push_back(p);
	endtask

	function automatic logic [CH_W-1:0] pick_level(input int unsigned mode);
		case (mode)
			2: begin
				case ($urandom_range(3))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd254;
					default: return 8'd255;
				endcase
			end
			3: return CH_W'($urandom_range(131, 128));
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	// Hold until nothing is pending or outstanding, then let the pipeline settle
	task automatic wait_idle();
		while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		int unsigned seen;
		seen = cfg_write_count;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		wait (cfg_write_count != seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame_size(input int unsigned w_val, input int unsigned h_val);
		write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w_val));
		write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
		frame_w = clamp_dim(w_val % (1 << FW_W), MAX_W);
		frame_h = clamp_dim(h_val % (1 << FH_W), MAX_H);
	endtask

	// Random pixels, the first one flagged as a frame start
	task automatic queue_frame(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			push_pixel(pick_level(0), pick_level(0), pick_level(0), i == 0);
		end
	endtask

	// Corners bright in red, center bright in green, ties in blue
	task automatic queue_corner_frame(input logic fs);
		push_pixel(8'd255, 8'd0, 8'd0, fs);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd0, 8'd255, 8'd1, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
	endtask

	// Mostly whole frames; some cut short, some with a stray restart
	task automatic queue_random_frames(input int unsigned target);
		int unsigned queued, n, mode;
		logic        start;
		queued = 0;
		start  = 1'b1;
		while (queued < target) begin
			n = frame_w * frame_h;
			if ($urandom_range(9) == 0) begin
				n = $urandom_range(n - 1, 1);
			end
			mode = $urandom_range(3);
			for (int unsigned i = 0; i < n; i++) begin
				push_pixel(pick_level(mode), pick_level(mode), pick_level(mode),
					(i == 0) ? start : ($urandom_range(199) == 0));
			end
			queued += n;
			start = ($urandom_range(3) != 0);
		end
	endtask

	task automatic run_mix(input int unsigned send_pct, input int unsigned stall);
		int unsigned w_val, h_val, sel;
		send_idle_pct = send_pct;
		stall_pct     = stall;
		repeat (2) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				w_val = $urandom_range(2);
			end else if (sel == 1) begin
				w_val = $urandom_range(40, 13);
			end else begin
				w_val = $urandom_range(12, 3);
			end
			h_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
			set_frame_size(w_val, h_val);
			queue_random_frames(MIX_ITEMS / 2);
			wait_idle();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size: too few lines for any result
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
		push_pixel(8'hF0, 8'h0F, 8'hFF, 1'b0);
		wait_idle();

		// Below-minimum sizes clamp to the smallest frame
		set_frame_size(0, 2);
		queue_corner_frame(1'b1);
		// Next frame follows by counter wrap alone, with tied levels
		for (int i = 0; i < 9; i++) begin
			push_pixel(i == 4 ? 8'd127 : 8'd128, i == 4 ? 8'd129 : 8'd128, 8'd128, 1'b0);
		end
		// Restart part way into a frame
		push_pixel(8'd9, 8'd200, 8'd37, 1'b0);
		push_pixel(8'd1, 8'd254, 8'd128, 1'b0);
		queue_corner_frame(1'b1);
		wait_idle();

		// Shrink the frame while the counters sit past the new size
		set_frame_size(5, 5);
		queue_frame(19);
		wait_idle();
		set_frame_size(3, 3);
		for (int i = 0; i < 10; i++) begin
			push_pixel(pick_level(0), pick_level(0), pick_level(0), 1'b0);
		end
		wait_idle();

		// Random frames under each idle and stall mix
		run_mix(0, 0);
		run_mix(46, 0);
		run_mix(0, 46);
		run_mix(26, 26);

		// Oversized register values: a short run at the largest width, then the top
		// of a frame at the largest height
		set_frame_size(2047, 3);
		queue_frame(40);
		wait_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
		set_frame_size(3, 8191);
		queue_frame(150);
		wait_idle();

		if (expected_pixels.size() != 0) begin
			fail_count += expected_pixels.size();
			$display("%0d filtered pixels never arrived", expected_pixels.size());
		end
		$display("Sent %0d pixels, checked %0d filtered pixels, made %0d register writes",
			pixels_sent, results_checked, cfg_write_count);
		$display("Frame sizes from clamped minimum to clamped maximum, resized and "
			, "restarted frames, four idle mixes");
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
